// ===== hw/rtl/plp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types, codes and character helpers for the peer list parser.
// ----------------------------------------------------------------------------
package plp_pkg;

    typedef enum logic [3:0] {
        PH_LIST_START,
        PH_ENTRY_START,
        PH_ID,
        PH_HOST,
        PH_PORT_FIRST,
        PH_PORT,
        PH_CPORT_FIRST,
        PH_CPORT,
        PH_ERROR
    } t_phase;

    typedef enum logic [3:0] {
        E_OK,
        E_CAPACITY,
        E_BAD_ID,
        E_NO_AT,
        E_HOST_CHAR,
        E_HOST_LEN,
        E_NO_COLON,
        E_PORT,
        E_CPORT,
        E_SEPARATOR,
        E_DUPLICATE,
        E_TRAILING
    } t_err;

    typedef enum logic [1:0] {
        KIND_HOST,
        KIND_ENTRY,
        KIND_STATUS
    } t_kind;

    typedef enum logic {
        CMD_CHAR,
        CMD_END
    } t_cmd;

    typedef struct packed {
        t_kind        kind;
        logic [3:0]   entry_index;
        logic [7:0]   host_char;
        logic [63:0]  peer_id;
        logic [15:0]  peer_port;
        logic [15:0]  cli_port;
        logic [6:0]   host_length;
        logic [4:0]   entry_count;
        t_err         error_code;
        logic         last;
    } t_result;

    // up to two results per input transaction, first in slot a
    typedef struct packed {
        logic [1:0] cnt;
        t_result    a;
        t_result    b;
    } t_push;

    // parser actions decided by the phase logic
    typedef struct packed {
        logic id_first;
        logic id_step;
        logic host_open;
        logic host_emit;
        logic port_first;
        logic port_step;
        logic cport_first;
        logic cport_step;
        logic complete;
        logic eol;
    } t_ctrl;

    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_AT     = 8'h40;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_SLASH  = 8'h2F;
    localparam logic [7:0]  CH_COMMA  = 8'h2C;
    localparam logic [20:0] PORT_LIMIT = 21'd65535;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return (c >= 8'h31) && (c <= 8'h39);
    endfunction

    function automatic logic is_host_char(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               is_digit(c) || (c == 8'h2E) || (c == 8'h2D);
    endfunction

endpackage

// ===== hw/rtl/plp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_parser
// Per-character parse state, id store and duplicate check; forms results.
// ----------------------------------------------------------------------------
module plp_parser #(
    parameter int unsigned MAX_PEERS = 16,
    parameter int unsigned HOST_MAX  = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [7:0]        i_char_code,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_data,
    output plp_pkg::t_push    o_push
);

    localparam int unsigned CW   = $clog2(MAX_PEERS + 1);
    localparam int unsigned IW   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int unsigned HW   = $clog2(HOST_MAX + 1);
    localparam int unsigned CMPW = (CW > 5) ? CW : 5;

    logic [4:0]        r_capacity;
    plp_pkg::t_phase   r_phase, n_phase;
    plp_pkg::t_err     r_err, n_err;
    logic [63:0]       r_id, n_id;
    logic [16:0]       r_port, n_port;
    logic [16:0]       r_cport, n_cport;
    logic [HW-1:0]     r_hc, n_hc;
    logic [CW-1:0]     r_count, n_count;
    logic [63:0]       r_ids [MAX_PEERS];

    plp_pkg::t_ctrl    ctrl;
    plp_pkg::t_err     eol_err;
    logic [3:0]        digit;
    logic [67:0]       id_next;
    logic              id_ovf;
    logic [20:0]       port_next, cport_next;
    logic [MAX_PEERS-1:0] match;
    logic              dup_hit, full, at_cap, entry_ok;
    plp_pkg::t_result  rec, host_res, status;

    assign digit = 4'(i_char_code - plp_pkg::CH_ZERO);

    // id * 10 + d as (id << 3) + (id << 1) + d, overflow shows in the top bits
    assign id_next = {1'b0, r_id, 3'b000} + {3'b000, r_id, 1'b0} + {64'd0, digit};
    assign id_ovf  = |id_next[67:64];

    assign port_next  = {4'd0, r_port} * 21'd10 + {17'd0, digit};
    assign cport_next = {4'd0, r_cport} * 21'd10 + {17'd0, digit};

    always_comb begin
        for (int i = 0; i < MAX_PEERS; i++) begin
            match[i] = (r_ids[i] == r_id) && (CMPW'(i) < CMPW'(r_count));
        end
    end

    assign dup_hit  = |match;
    assign full     = CMPW'(r_count) >= CMPW'(MAX_PEERS);
    assign at_cap   = (CMPW'(r_capacity) > CMPW'(MAX_PEERS))
                      ? full : (CMPW'(r_count) >= CMPW'(r_capacity));
    assign entry_ok = !dup_hit && !full;

    // next phase and first error
    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        eol_err = plp_pkg::E_OK;
        ctrl    = '0;
        if (i_accept) begin
            if (i_command == plp_pkg::CMD_END) begin
                ctrl.eol = 1'b1;
                n_phase  = plp_pkg::PH_LIST_START;
                n_err    = plp_pkg::E_OK;
                unique case (r_phase)
                    plp_pkg::PH_LIST_START:  eol_err = plp_pkg::E_OK;
                    plp_pkg::PH_ENTRY_START: eol_err = plp_pkg::E_TRAILING;
                    plp_pkg::PH_ID:          eol_err = plp_pkg::E_NO_AT;
                    plp_pkg::PH_HOST:
                        eol_err = (r_hc == '0) ? plp_pkg::E_HOST_LEN : plp_pkg::E_NO_COLON;
                    plp_pkg::PH_PORT_FIRST:  eol_err = plp_pkg::E_PORT;
                    plp_pkg::PH_CPORT_FIRST: eol_err = plp_pkg::E_CPORT;
                    plp_pkg::PH_PORT, plp_pkg::PH_CPORT: begin
                        ctrl.complete = 1'b1;
                        if (dup_hit) begin
                            eol_err = plp_pkg::E_DUPLICATE;
                        end else if (full) begin
                            eol_err = plp_pkg::E_CAPACITY;
                        end
                    end
                    plp_pkg::PH_ERROR:       eol_err = r_err;
                    default:                 eol_err = plp_pkg::E_OK;
                endcase
            end else begin
                unique case (r_phase)
                    plp_pkg::PH_LIST_START, plp_pkg::PH_ENTRY_START: begin
                        priority if (r_phase == plp_pkg::PH_LIST_START &&
                                     i_char_code == plp_pkg::CH_COMMA) begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_SEPARATOR;
                        end else if (at_cap) begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_CAPACITY;
                        end else if (!plp_pkg::is_lead(i_char_code)) begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_BAD_ID;
                        end else begin
                            n_phase       = plp_pkg::PH_ID;
                            ctrl.id_first = 1'b1;
                        end
                    end
                    plp_pkg::PH_ID: begin
                        priority if (plp_pkg::is_digit(i_char_code)) begin
                            if (id_ovf) begin
                                n_phase = plp_pkg::PH_ERROR;
                                n_err   = plp_pkg::E_BAD_ID;
                            end else begin
                                ctrl.id_step = 1'b1;
                            end
                        end else if (i_char_code == plp_pkg::CH_AT) begin
                            n_phase        = plp_pkg::PH_HOST;
                            ctrl.host_open = 1'b1;
                        end else begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_NO_AT;
                        end
                    end
                    plp_pkg::PH_HOST: begin
                        priority if (i_char_code == plp_pkg::CH_COLON) begin
                            if (r_hc == '0) begin
                                n_phase = plp_pkg::PH_ERROR;
                                n_err   = plp_pkg::E_HOST_LEN;
                            end else begin
                                n_phase = plp_pkg::PH_PORT_FIRST;
                            end
                        end else if (i_char_code == plp_pkg::CH_COMMA) begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = (r_hc == '0) ? plp_pkg::E_HOST_LEN
                                                   : plp_pkg::E_NO_COLON;
                        end else if (!plp_pkg::is_host_char(i_char_code)) begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_HOST_CHAR;
                        end else if (r_hc >= HW'(HOST_MAX)) begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_HOST_LEN;
                        end else begin
                            ctrl.host_emit = 1'b1;
                        end
                    end
                    plp_pkg::PH_PORT_FIRST, plp_pkg::PH_CPORT_FIRST: begin
                        if (plp_pkg::is_lead(i_char_code)) begin
                            if (r_phase == plp_pkg::PH_PORT_FIRST) begin
                                n_phase         = plp_pkg::PH_PORT;
                                ctrl.port_first = 1'b1;
                            end else begin
                                n_phase          = plp_pkg::PH_CPORT;
                                ctrl.cport_first = 1'b1;
                            end
                        end else begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = (r_phase == plp_pkg::PH_PORT_FIRST)
                                      ? plp_pkg::E_PORT : plp_pkg::E_CPORT;
                        end
                    end
                    plp_pkg::PH_PORT, plp_pkg::PH_CPORT: begin
                        priority if (plp_pkg::is_digit(i_char_code)) begin
                            if (r_phase == plp_pkg::PH_PORT) begin
                                ctrl.port_step = 1'b1;
                                if (port_next > plp_pkg::PORT_LIMIT) begin
                                    n_phase = plp_pkg::PH_ERROR;
                                    n_err   = plp_pkg::E_PORT;
                                end
                            end else begin
                                ctrl.cport_step = 1'b1;
                                if (cport_next > plp_pkg::PORT_LIMIT) begin
                                    n_phase = plp_pkg::PH_ERROR;
                                    n_err   = plp_pkg::E_CPORT;
                                end
                            end
                        end else if (r_phase == plp_pkg::PH_PORT &&
                                     i_char_code == plp_pkg::CH_SLASH) begin
                            n_phase = plp_pkg::PH_CPORT_FIRST;
                        end else if (i_char_code == plp_pkg::CH_COMMA) begin
                            ctrl.complete = 1'b1;
                            priority if (dup_hit) begin
                                n_phase = plp_pkg::PH_ERROR;
                                n_err   = plp_pkg::E_DUPLICATE;
                            end else if (full) begin
                                n_phase = plp_pkg::PH_ERROR;
                                n_err   = plp_pkg::E_CAPACITY;
                            end else begin
                                n_phase = plp_pkg::PH_ENTRY_START;
                            end
                        end else begin
                            n_phase = plp_pkg::PH_ERROR;
                            n_err   = plp_pkg::E_SEPARATOR;
                        end
                    end
                    plp_pkg::PH_ERROR: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        n_phase = plp_pkg::PH_ERROR;
                    end
                endcase
            end
        end
    end

    // datapath next values and results
    always_comb begin
        n_id    = r_id;
        n_port  = r_port;
        n_cport = r_cport;
        n_hc    = r_hc;
        n_count = r_count;

        host_res             = '0;
        host_res.kind        = plp_pkg::KIND_HOST;
        host_res.entry_index = 4'(r_count);
        host_res.host_char   = i_char_code;

        rec             = '0;
        rec.kind        = plp_pkg::KIND_ENTRY;
        rec.entry_index = 4'(r_count);
        rec.peer_id     = r_id;
        rec.peer_port   = r_port[15:0];
        rec.cli_port    = r_cport[15:0];
        rec.host_length = 7'(r_hc);
        rec.entry_count = 5'(r_count + 1'b1);

        status            = '0;
        status.kind       = plp_pkg::KIND_STATUS;
        status.entry_count = (ctrl.complete && entry_ok) ? 5'(r_count + 1'b1)
                                                         : 5'(r_count);
        status.error_code = eol_err;
        status.last       = 1'b1;

        o_push = '0;

        if (ctrl.id_first) begin
            n_id    = {60'd0, digit};
            n_port  = '0;
            n_cport = '0;
            n_hc    = '0;
        end
        if (ctrl.id_step)     n_id    = id_next[63:0];
        if (ctrl.host_open)   n_hc    = '0;
        if (ctrl.host_emit)   n_hc    = r_hc + 1'b1;
        if (ctrl.port_first)  n_port  = {13'd0, digit};
        if (ctrl.port_step)   n_port  = port_next[16:0];
        if (ctrl.cport_first) n_cport = {13'd0, digit};
        if (ctrl.cport_step)  n_cport = cport_next[16:0];
        if (ctrl.complete && entry_ok) n_count = r_count + 1'b1;

        if (ctrl.host_emit) begin
            o_push.cnt = 2'd1;
            o_push.a   = host_res;
        end else if (ctrl.eol) begin
            if (ctrl.complete && entry_ok) begin
                o_push.cnt = 2'd2;
                o_push.a   = rec;
                o_push.b   = status;
            end else begin
                o_push.cnt = 2'd1;
                o_push.a   = status;
            end
        end else if (ctrl.complete && entry_ok) begin
            o_push.cnt = 2'd1;
            o_push.a   = rec;
        end

        // end of list starts a fresh list
        if (ctrl.eol) begin
            n_id    = '0;
            n_port  = '0;
            n_cport = '0;
            n_hc    = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 5'd16;
            r_phase    <= plp_pkg::PH_LIST_START;
            r_err      <= plp_pkg::E_OK;
            r_id       <= '0;
            r_port     <= '0;
            r_cport    <= '0;
            r_hc       <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_err   <= n_err;
            r_id    <= n_id;
            r_port  <= n_port;
            r_cport <= n_cport;
            r_hc    <= n_hc;
            r_count <= n_count;
        end
    end

    // id store, one row per accepted entry
    always_ff @(posedge i_clk) begin
        if (ctrl.complete && entry_ok) begin
            r_ids[r_count[IW-1:0]] <= r_id;
        end
    end

endmodule

// ===== hw/rtl/plp_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_out_queue
// Small result queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module plp_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plp_pkg::t_push    i_push,
    input  logic              i_pop,
    output plp_pkg::t_result  o_head,
    output logic              o_valid,
    output logic              o_full
);

    plp_pkg::t_result                  r_mem [plp_pkg::QDEPTH];
    logic [plp_pkg::QAW-1:0]           r_wr, n_wr;
    logic [plp_pkg::QAW-1:0]           r_rd, n_rd;
    logic [plp_pkg::QAW:0]             r_cnt, n_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    // room for two results must be there before a transaction is taken
    assign o_full  = (r_cnt > (plp_pkg::QAW + 1)'(plp_pkg::QDEPTH - 2));

    always_comb begin
        n_wr  = r_wr + plp_pkg::QAW'(i_push.cnt);
        n_rd  = r_rd + plp_pkg::QAW'(i_pop);
        n_cnt = r_cnt + (plp_pkg::QAW + 1)'(i_push.cnt) - (plp_pkg::QAW + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.b;
        end
    end

endmodule

// ===== hw/rtl/peer_list_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_list_parser_top
// Streaming parser for "id@host:port[/clientport]" peer lists.
// ----------------------------------------------------------------------------
// One list character or end-of-list marker is taken per clock while the
// input is not stalled. Each transaction is parsed in the cycle it is
// accepted and its results are written to a four-entry result queue, which
// registers them before they show on the output. A host character gives one
// result, a comma that closes an entry gives one record, end of list gives
// the status (preceded by the record when it closes an entry). The input
// stalls only while the queue holds more than two results, so with the
// output draining the block keeps one transaction per cycle; the sustained
// rate is set by the single output port, which moves one result per cycle.
module peer_list_parser_top #(
    parameter int unsigned MAX_PEERS = 16,
    parameter int unsigned HOST_MAX  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_char_code,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_entry_index,
    output logic [7:0]  o_host_char,
    output logic [63:0] o_peer_id,
    output logic [15:0] o_peer_port,
    output logic [15:0] o_cli_port,
    output logic [6:0]  o_host_length,
    output logic [4:0]  o_entry_count,
    output logic [3:0]  o_error_code,
    output logic        o_last
);

    plp_pkg::t_push   push;
    plp_pkg::t_result head;
    logic             q_full;
    logic             accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    plp_parser #(
        .MAX_PEERS (MAX_PEERS),
        .HOST_MAX  (HOST_MAX)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push)
    );

    plp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_valid && !i_stall),
        .o_head  (head),
        .o_valid (o_valid),
        .o_full  (q_full)
    );

    assign o_kind        = head.kind;
    assign o_entry_index = head.entry_index;
    assign o_host_char   = head.host_char;
    assign o_peer_id     = head.peer_id;
    assign o_peer_port   = head.peer_port;
    assign o_cli_port    = head.cli_port;
    assign o_host_length = head.host_length;
    assign o_entry_count = head.entry_count;
    assign o_error_code  = head.error_code;
    assign o_last        = head.last;

endmodule

// ===== hw/rtl/plp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plp_checker
// Port-level checks on the peer list parser result stream.
// ----------------------------------------------------------------------------
module plp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_kind,
    input  logic [3:0]  o_entry_index,
    input  logic [7:0]  o_host_char,
    input  logic [63:0] o_peer_id,
    input  logic [15:0] o_peer_port,
    input  logic [15:0] o_cli_port,
    input  logic [6:0]  o_host_length,
    input  logic [4:0]  o_entry_count,
    input  logic [3:0]  o_error_code,
    input  logic        o_last
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_entry_index) &&
            $stable(o_host_char) && $stable(o_peer_id) && $stable(o_peer_port) &&
            $stable(o_cli_port) && $stable(o_host_length) && $stable(o_entry_count) &&
            $stable(o_error_code) && $stable(o_last))
        else $error("stalled result changed");

    // last flags the status transaction and nothing else
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind == plp_pkg::KIND_STATUS)))
        else $error("last does not match status kind");

    // a record counts itself
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == plp_pkg::KIND_ENTRY |->
            o_entry_count == 5'(o_entry_index) + 5'd1)
        else $error("record count does not follow its index");

    // host characters and records carry no error code
    a_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == plp_pkg::KIND_HOST || o_kind == plp_pkg::KIND_ENTRY) |->
            o_error_code == plp_pkg::E_OK)
        else $error("error code on a non-status result");

endmodule

bind peer_list_parser_top plp_checker u_plp_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peer list parser.
// ----------------------------------------------------------------------------
// Peer lists go in one character per transaction. A software copy of the
// parser works out the host characters, entry records and list statuses that
// each accepted transaction should give, and every result leaving the block
// is checked field by field against the oldest one still outstanding.
// Directed lists come first, then full-capacity lists and random lists (mostly
// well formed, some damaged, some noise) under three idling mixes, with a long
// receiver hold-off before the last mix and the capacity register changed between lists.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MAX_PEERS   = 16;
    localparam int unsigned HOST_MAX    = 64;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_command   = 1'b0;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_cfg_we    = 1'b0;
    logic [4:0]  i_cfg_data  = 5'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_entry_index;
    logic [7:0]  o_host_char;
    logic [63:0] o_peer_id;
    logic [15:0] o_peer_port;
    logic [15:0] o_cli_port;
    logic [6:0]  o_host_length;
    logic [4:0]  o_entry_count;
    logic [3:0]  o_error_code;
    logic        o_last;

    peer_list_parser_top #(
        .MAX_PEERS(MAX_PEERS),
        .HOST_MAX (HOST_MAX)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_entry_index(o_entry_index),
        .o_host_char  (o_host_char),
        .o_peer_id    (o_peer_id),
        .o_peer_port  (o_peer_port),
        .o_cli_port   (o_cli_port),
        .o_host_length(o_host_length),
        .o_entry_count(o_entry_count),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // parser state as the bench sees it
    // ------------------------------------------------------------------
    plp_pkg::t_phase ps_phase;
    logic [63:0]     ps_id;
    int unsigned     ps_port;
    int unsigned     ps_cport;
    int unsigned     ps_hosts;
    int unsigned     ps_count;
    logic [63:0]     ps_ids [MAX_PEERS];
    plp_pkg::t_err   ps_err;
    logic [4:0]      ps_capacity;

    plp_pkg::t_result pending_results[$];
    plp_pkg::t_result head;

    int unsigned items_parsed  = 0;
    int unsigned lists_sent    = 0;
    int unsigned cfg_writes    = 0;
    int unsigned results_seen  = 0;
    int unsigned records_seen  = 0;
    int unsigned status_seen[16];
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_request  = 0;
    int unsigned hold_left     = 0;

    logic [7:0]  list_text[$];
    logic [63:0] list_ids[$];
    string       host_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.-";
    string       noise_alphabet = "@:/,,0123456789aZ.- ";

    function automatic logic is_num(input logic [7:0] c);
        return c >= plp_pkg::CH_ZERO && c <= plp_pkg::CH_ZERO + 8'd9;
    endfunction

    function automatic logic is_first_num(input logic [7:0] c);
        return c > plp_pkg::CH_ZERO && c <= plp_pkg::CH_ZERO + 8'd9;
    endfunction

    function automatic logic is_host_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || is_num(c) ||
               c == "." || c == "-";
    endfunction

    function automatic void push_result(input plp_pkg::t_kind k, input int unsigned idx,
                                        input logic [7:0] hc, input logic [63:0] id,
                                        input int unsigned port, input int unsigned cport,
                                        input int unsigned hlen, input int unsigned cnt,
                                        input plp_pkg::t_err err, input logic last);
        plp_pkg::t_result r;
        r.kind        = k;
        r.entry_index = idx[3:0];
        r.host_char   = hc;
        r.peer_id     = id;
        r.peer_port   = port[15:0];
        r.cli_port    = cport[15:0];
        r.host_length = hlen[6:0];
        r.entry_count = cnt[4:0];
        r.error_code  = err;
        r.last        = last;
        pending_results.push_back(r);
    endfunction

    function automatic void fault(input plp_pkg::t_err code);
        ps_err   = code;
        ps_phase = plp_pkg::PH_ERROR;
    endfunction

    function automatic void clear_list();
        ps_phase = plp_pkg::PH_LIST_START;
        ps_id    = '0;
        ps_port  = 0;
        ps_cport = 0;
        ps_hosts = 0;
        ps_count = 0;
        ps_err   = plp_pkg::E_OK;
    endfunction

    function automatic void finish_entry();
        int unsigned i;
        for (i = 0; i < ps_count && i < MAX_PEERS; i++) begin
            if (ps_ids[i] == ps_id) begin
                fault(plp_pkg::E_DUPLICATE);
                return;
            end
        end
        if (ps_count >= MAX_PEERS) begin
            fault(plp_pkg::E_CAPACITY);
            return;
        end
        ps_ids[ps_count] = ps_id;
        push_result(plp_pkg::KIND_ENTRY, ps_count, 8'd0, ps_id, ps_port, ps_cport,
                    ps_hosts, ps_count + 1, plp_pkg::E_OK, 1'b0);
        ps_count++;
    endfunction

    function automatic void open_entry(input logic [7:0] c);
        int unsigned cap;
        cap = (ps_capacity > MAX_PEERS) ? MAX_PEERS : ps_capacity;
        if (ps_count >= cap) begin
            fault(plp_pkg::E_CAPACITY);
        end else if (!is_first_num(c)) begin
            fault(plp_pkg::E_BAD_ID);
        end else begin
            ps_id    = 64'(c - plp_pkg::CH_ZERO);
            ps_port  = 0;
            ps_cport = 0;
            ps_hosts = 0;
            ps_phase = plp_pkg::PH_ID;
        end
    endfunction

    function automatic void close_list();
        plp_pkg::t_err code;
        case (ps_phase)
            plp_pkg::PH_ENTRY_START: fault(plp_pkg::E_TRAILING);
            plp_pkg::PH_ID:          fault(plp_pkg::E_NO_AT);
            plp_pkg::PH_HOST: begin
                if (ps_hosts == 0) fault(plp_pkg::E_HOST_LEN);
                else fault(plp_pkg::E_NO_COLON);
            end
            plp_pkg::PH_PORT_FIRST:  fault(plp_pkg::E_PORT);
            plp_pkg::PH_CPORT_FIRST: fault(plp_pkg::E_CPORT);
            plp_pkg::PH_PORT, plp_pkg::PH_CPORT: finish_entry();
            default: ;
        endcase
        if (ps_phase == plp_pkg::PH_ERROR) code = ps_err;
        else code = plp_pkg::E_OK;
        push_result(plp_pkg::KIND_STATUS, 0, 8'd0, 64'd0, 0, 0, 0, ps_count, code, 1'b1);
        clear_list();
    endfunction

    // works out the results of one accepted transaction
    function automatic void parse_item(input plp_pkg::t_cmd cmd, input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] lim;
        d = 64'(c) - 64'(plp_pkg::CH_ZERO);
        items_parsed++;
        if (cmd == plp_pkg::CMD_END) begin
            close_list();
            return;
        end
        case (ps_phase)
            plp_pkg::PH_LIST_START: begin
                if (c == plp_pkg::CH_COMMA) fault(plp_pkg::E_SEPARATOR);
                else open_entry(c);
            end
            plp_pkg::PH_ENTRY_START: open_entry(c);
            plp_pkg::PH_ID: begin
                if (is_num(c)) begin
                    lim = (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10;
                    if (ps_id > lim) fault(plp_pkg::E_BAD_ID);
                    else ps_id = ps_id * 64'd10 + d;
                end else if (c == plp_pkg::CH_AT) begin
                    ps_hosts = 0;
                    ps_phase = plp_pkg::PH_HOST;
                end else begin
                    fault(plp_pkg::E_NO_AT);
                end
            end
            plp_pkg::PH_HOST: begin
                if (c == plp_pkg::CH_COLON) begin
                    if (ps_hosts == 0) fault(plp_pkg::E_HOST_LEN);
                    else ps_phase = plp_pkg::PH_PORT_FIRST;
                end else if (c == plp_pkg::CH_COMMA) begin
                    if (ps_hosts == 0) fault(plp_pkg::E_HOST_LEN);
                    else fault(plp_pkg::E_NO_COLON);
                end else if (!is_host_byte(c)) begin
                    fault(plp_pkg::E_HOST_CHAR);
                end else if (ps_hosts >= HOST_MAX) begin
                    fault(plp_pkg::E_HOST_LEN);
                end else begin
                    push_result(plp_pkg::KIND_HOST, ps_count, c, 64'd0, 0, 0, 0, 0,
                                plp_pkg::E_OK, 1'b0);
                    ps_hosts++;
                end
            end
            plp_pkg::PH_PORT_FIRST: begin
                if (is_first_num(c)) begin
                    ps_port  = 32'(d);
                    ps_phase = plp_pkg::PH_PORT;
                end else begin
                    fault(plp_pkg::E_PORT);
                end
            end
            plp_pkg::PH_CPORT_FIRST: begin
                if (is_first_num(c)) begin
                    ps_cport = 32'(d);
                    ps_phase = plp_pkg::PH_CPORT;
                end else begin
                    fault(plp_pkg::E_CPORT);
                end
            end
            plp_pkg::PH_PORT, plp_pkg::PH_CPORT: begin
                if (is_num(c)) begin
                    if (ps_phase == plp_pkg::PH_PORT) begin
                        ps_port = ps_port * 10 + 32'(d);
                        if (ps_port > 65535) fault(plp_pkg::E_PORT);
                    end else begin
                        ps_cport = ps_cport * 10 + 32'(d);
                        if (ps_cport > 65535) fault(plp_pkg::E_CPORT);
                    end
                end else if (c == plp_pkg::CH_SLASH && ps_phase == plp_pkg::PH_PORT) begin
                    ps_phase = plp_pkg::PH_CPORT_FIRST;
                end else if (c == plp_pkg::CH_COMMA) begin
                    finish_entry();
                    if (ps_phase != plp_pkg::PH_ERROR) ps_phase = plp_pkg::PH_ENTRY_START;
                end else begin
                    fault(plp_pkg::E_SEPARATOR);
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // list text builders
    // ------------------------------------------------------------------
    function automatic void add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) list_text.push_back(s[i]);
    endfunction

    function automatic void add_dec(input logic [63:0] v);
        logic [7:0] digits[$];
        if (v == 0) digits.push_back(plp_pkg::CH_ZERO);
        while (v != 0) begin
            digits.push_front(plp_pkg::CH_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end
        foreach (digits[i]) list_text.push_back(digits[i]);
    endfunction

    function automatic void add_host(input int n);
        int i;
        for (i = 0; i < n; i++)
            list_text.push_back(host_alphabet[$urandom_range(0, host_alphabet.len() - 1)]);
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0)
            return noise_alphabet[$urandom_range(0, noise_alphabet.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_port();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            list_text.push_back(plp_pkg::CH_ZERO);  // leading zero
            add_dec($urandom_range(0, 999));
        end else if (r < 10) begin
            add_dec($urandom_range(65536, 99999));  // out of range
        end else if (r < 15) begin
            add_dec(64'd65535);
        end else if (r < 20) begin
            add_dec(64'd1);
        end else begin
            add_dec($urandom_range(1, 65535));
        end
    endfunction

    function automatic void add_entry();
        int r;
        int h;
        logic [63:0] id;
        r = $urandom_range(0, 99);
        if (r < 8 && list_ids.size() != 0)
            id = list_ids[$urandom_range(0, list_ids.size() - 1)];
        else if (r < 55) id = $urandom_range(1, 999);
        else if (r < 72) id = {$urandom, $urandom} | 64'd1;
        else if (r < 80) id = '1;
        else id = {$urandom, $urandom} >> $urandom_range(0, 63);
        if (r >= 92) begin
            // one step past the 64-bit range
            if ($urandom_range(0, 1) == 0) add_str("18446744073709551616");
            else begin
                add_dec('1);
                list_text.push_back(plp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end else begin
            add_dec(id);
            list_ids.push_back(id);
        end
        list_text.push_back(plp_pkg::CH_AT);
        h = $urandom_range(0, 99);
        if (h < 84) add_host($urandom_range(1, 8));
        else if (h < 90) add_host(HOST_MAX);
        else if (h < 94) add_host(HOST_MAX + 1);
        else add_host($urandom_range(9, HOST_MAX - 1));
        list_text.push_back(plp_pkg::CH_COLON);
        add_port();
        if ($urandom_range(0, 99) < 40) begin
            list_text.push_back(plp_pkg::CH_SLASH);
            add_port();
        end
    endfunction

    function automatic void damage_list();
        int pos;
        if (list_text.size() == 0) begin
            list_text.push_back(noise_byte());
            return;
        end
        pos = $urandom_range(0, list_text.size() - 1);
        case ($urandom_range(0, 4))
            0: list_text[pos] = noise_byte();
            1: list_text.delete(pos);
            2: while (list_text.size() > pos) void'(list_text.pop_back());
            3: list_text.push_back(plp_pkg::CH_COMMA);
            default: list_text.insert(pos, noise_byte());
        endcase
    endfunction

    function automatic void build_list();
        int r;
        int entries;
        int i;
        list_text.delete();
        list_ids.delete();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 12)) list_text.push_back(noise_byte());
            return;
        end
        if (r < 15) entries = 0;
        else if (r < 19) entries = MAX_PEERS + 1;
        else entries = $urandom_range(1, 4);
        for (i = 0; i < entries; i++) begin
            if (i != 0) list_text.push_back(plp_pkg::CH_COMMA);
            add_entry();
        end
        if ($urandom_range(0, 99) < 30) damage_list();
    endfunction

    function automatic void build_numbered(input int n);
        int i;
        list_text.delete();
        for (i = 1; i <= n; i++) begin
            if (i != 1) list_text.push_back(plp_pkg::CH_COMMA);
            add_dec(i);
            add_str("@h:1");
        end
    endfunction

    function automatic logic [4:0] pick_capacity();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 5'd0;
        if (r < 40) return 5'($urandom_range(1, 4));
        if (r < 65) return 5'd16;
        if (r < 80) return 5'd31;
        return 5'($urandom_range(0, 31));
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    // entered and left at a falling edge; valid stays up for back-to-back items
    task automatic send_item(input plp_pkg::t_cmd cmd, input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_item(cmd, c);
        @(negedge i_clk);
    endtask

    task automatic send_list();
        foreach (list_text[i]) send_item(plp_pkg::CMD_CHAR, list_text[i]);
        send_item(plp_pkg::CMD_END, 8'($urandom_range(0, 255)));
        lists_sent++;
    endtask

    task automatic send_text(input string s);
        list_text.delete();
        add_str(s);
        send_list();
    endtask

    // stop sending and wait for the output to drain
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ps_capacity  = v;
        cfg_writes++;
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                 $time, what, got, want, results_seen);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", o_kind, 0);
            end else begin
                head = pending_results.pop_front();
                if (o_kind !== head.kind) report_mismatch("kind", o_kind, head.kind);
                if (o_entry_index !== head.entry_index)
                    report_mismatch("entry_index", o_entry_index, head.entry_index);
                if (o_host_char !== head.host_char)
                    report_mismatch("host_char", o_host_char, head.host_char);
                if (o_peer_id !== head.peer_id)
                    report_mismatch("peer_id", o_peer_id, head.peer_id);
                if (o_peer_port !== head.peer_port)
                    report_mismatch("peer_port", o_peer_port, head.peer_port);
                if (o_cli_port !== head.cli_port)
                    report_mismatch("cli_port", o_cli_port, head.cli_port);
                if (o_host_length !== head.host_length)
                    report_mismatch("host_length", o_host_length, head.host_length);
                if (o_entry_count !== head.entry_count)
                    report_mismatch("entry_count", o_entry_count, head.entry_count);
                if (o_error_code !== head.error_code)
                    report_mismatch("error_code", o_error_code, head.error_code);
                if (o_last !== head.last) report_mismatch("last", o_last, head.last);
                if (head.kind == plp_pkg::KIND_ENTRY) records_seen++;
                if (head.kind == plp_pkg::KIND_STATUS) status_seen[head.error_code]++;
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        send_idle_pct = 21;
        recv_idle_pct = 49;
        send_text("");                  // empty list
        send_text(",");                 // comma before any entry
        send_text("1@A:9,");            // record on the comma, then trailing comma
        send_text("9@z-.0:65535/1");    // record closed by end of list
        write_capacity(5'd0);
        send_text("1");                 // no room for a single entry
        write_capacity(5'd16);
        settle();
    endtask

    task automatic test_capacity_limit();
        write_capacity(5'd31);          // clipped to the peer table size
        build_numbered(MAX_PEERS + 1);
        send_list();
        write_capacity(5'd16);
        build_numbered(MAX_PEERS);
        send_list();
        build_numbered(MAX_PEERS + 1);
        send_list();
        settle();
    endtask

    // receiver holds off while a long host fills the result queue
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 150;
        list_text.delete();
        add_str("7@");
        add_host(48);
        add_str(":80/443");
        send_list();
        settle();
    endtask

    task automatic test_random_lists(input int unsigned s_pct, input int unsigned r_pct,
                                     input int unsigned quota);
        int unsigned stop_at;
        int unsigned n;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at       = items_parsed + quota;
        n             = 0;
        while (items_parsed < stop_at) begin
            if (n % 8 == 0) write_capacity(pick_capacity());
            build_list();
            send_list();
            n++;
        end
        settle();
    endtask

    initial begin
        int kinds;
        ps_capacity = 5'd16;
        clear_list();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_capacity_limit();
        test_random_lists(21, 49, 450);
        test_random_lists(49, 21, 450);
        test_backpressure();
        test_random_lists(0, 0, 450);

        settle();
        repeat (16) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        kinds = 0;
        foreach (status_seen[i]) if (status_seen[i] != 0) kinds++;
        $display("Parsed %0d transactions in %0d lists with %0d capacity writes.",
                 items_parsed, lists_sent, cfg_writes);
        $display("Checked %0d results: %0d entry records, %0d of 12 status codes seen.",
                 results_seen, records_seen, kinds);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
